>>> rtl/semaphore_wait_queue_table_core_defines.svh
// ---------------------------------------------------------------------------
// Semaphore wait queue table assertion macros
// Shared property shorthands for the control checks of the table.
// ---------------------------------------------------------------------------
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_CORE_DEFINES_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWQT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWQT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/swqt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Semaphore wait queue table package
// Operation and status codes, field widths and controller interface types.
// ---------------------------------------------------------------------------
package swqt_pkg;

	localparam int PID_W = 4;
	localparam int NUM_PIDS = 16;
	localparam int KEY_W = 31;
	localparam int DESC_W = KEY_W + 2 * PID_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_OUT = 2'd2;
	localparam logic [1:0] OP_HEAD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_PROC = 2'd1;
	localparam logic [1:0] RES_HEAD = 2'd2;

	typedef struct packed {
		logic load;
		logic init;
		logic hit;
		logic step;
		logic ins_append;
		logic ins_new;
		logic from_head;
		logic rd_next;
		logic walk;
		logic walk_step;
		logic unlink_head;
		logic unlink_mid;
		logic res_wr;
		logic [1:0] res_status;
		logic [1:0] res_sel;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic waiting;
		logic match;
		logic scan_last;
		logic found;
		logic free_found;
		logic head_is_p;
		logic tail_is_p;
		logic prev_is_tail;
		logic next_is_p;
		logic cnt_last;
	} sts_t;

endpackage

>>> rtl/swqt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module swqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/swqt_ctrl.sv
`timescale 1ns / 1ps
`include "semaphore_wait_queue_table_core_defines.svh"
// ---------------------------------------------------------------------------
// Semaphore wait queue table controller
// Sequences descriptor search, queue update and the result transfer.
// ---------------------------------------------------------------------------
module swqt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  swqt_pkg::sts_t  sts,
	output swqt_pkg::cmd_t  cmd
);
	import swqt_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_CMP = 4'd3;
	localparam logic [3:0] S_ACT = 4'd4;
	localparam logic [3:0] S_NXT = 4'd5;
	localparam logic [3:0] S_HEAD = 4'd6;
	localparam logic [3:0] S_WALK = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.init = 1'b1;
				if ((sts.op == OP_INSERT && sts.waiting) ||
				    (sts.op == OP_OUT && !sts.waiting)) begin
					cmd.res_wr = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					cmd.res_sel = RES_ZERO;
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_d = S_ACT;
				end else begin
					cmd.step = 1'b1;
					state_d = sts.scan_last ? S_ACT : S_RD;
				end
			end
			S_ACT: begin
				cmd.res_wr = 1'b1;
				cmd.res_status = ST_NOT_FOUND;
				cmd.res_sel = RES_ZERO;
				state_d = S_DONE;
				case (sts.op)
					OP_INSERT: begin
						if (sts.found) begin
							cmd.ins_append = 1'b1;
							cmd.res_status = ST_OK;
						end else if (sts.free_found) begin
							cmd.ins_new = 1'b1;
							cmd.res_status = ST_OK;
						end else begin
							cmd.res_status = ST_FULL;
						end
					end
					OP_HEAD: begin
						if (sts.found) begin
							cmd.res_status = ST_OK;
							cmd.res_sel = RES_HEAD;
						end
					end
					OP_REMOVE: begin
						if (sts.found) begin
							cmd.res_wr = 1'b0;
							cmd.from_head = 1'b1;
							state_d = S_NXT;
						end
					end
					default: begin
						if (sts.found) begin
							cmd.res_wr = 1'b0;
							state_d = S_NXT;
						end
					end
				endcase
			end
			S_NXT: begin
				cmd.rd_next = 1'b1;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				if (sts.head_is_p) begin
					cmd.unlink_head = 1'b1;
					cmd.res_wr = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_sel = RES_PROC;
					state_d = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.prev_is_tail) begin
					cmd.res_wr = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					cmd.res_sel = RES_ZERO;
					state_d = S_DONE;
				end else if (sts.next_is_p) begin
					cmd.unlink_mid = 1'b1;
					cmd.res_wr = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_sel = RES_PROC;
					state_d = S_DONE;
				end else if (sts.cnt_last) begin
					cmd.res_wr = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					cmd.res_sel = RES_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SWQT_ASSERT_NEXT(a_done_delivers, clk, arst_n, (state_q == S_DONE) && out_free, (state_q == S_IDLE) && out_valid_q, "finished result was not loaded")
	`SWQT_ASSERT_NEXT(a_scan_continues, clk, arst_n, (state_q == S_CMP) && !sts.match && !sts.scan_last, state_q == S_RD, "descriptor scan stopped early")
	`SWQT_ASSERT_NOW(a_idle_no_pending, clk, arst_n, (state_q == S_IDLE) && out_valid_q && out_stall, !cmd.out_load, "result loaded over a waiting result")

endmodule

>>> rtl/swqt_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Semaphore wait queue table datapath
// Descriptor memory, process link arrays, scan and walk registers, results.
// ---------------------------------------------------------------------------
module swqt_dpath #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    op,
	input  logic [swqt_pkg::KEY_W-1:0]    sem_addr,
	input  logic [swqt_pkg::PID_W-1:0]    proc_id,
	input  swqt_pkg::cmd_t                cmd,
	output swqt_pkg::sts_t                sts,
	output logic [1:0]                    status,
	output logic [swqt_pkg::PID_W-1:0]    result_proc
);
	import swqt_pkg::*;

	localparam int IW = $clog2(MAX_PROCS);

	logic [MAX_PROCS-1:0] in_use_q;
	logic [NUM_PIDS-1:0]  waiting_q;
	logic [PID_W-1:0]     next_q [NUM_PIDS];
	logic [KEY_W-1:0]     wkey_q [NUM_PIDS];

	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [PID_W-1:0] p_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    d_q;
	logic [IW-1:0]    free_q;
	logic             found_q;
	logic             free_found_q;
	logic [PID_W-1:0] head_d_q;
	logic [PID_W-1:0] tail_d_q;
	logic [PID_W-1:0] nextp_q;
	logic [PID_W-1:0] prev_q;
	logic [PID_W-1:0] cnt_q;
	logic [1:0]       res_status_q;
	logic [PID_W-1:0] res_proc_q;
	logic [1:0]       status_q;
	logic [PID_W-1:0] result_proc_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [DESC_W-1:0] ram_wdata;
	logic [DESC_W-1:0] ram_rdata;
	logic [PID_W-1:0]  next_rd;

	swqt_ram #(.WIDTH(DESC_W), .DEPTH(MAX_PROCS)) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign next_rd = next_q[cmd.walk ? prev_q : p_q];

	always_comb begin
		sts.op = op_q;
		sts.waiting = waiting_q[p_q];
		sts.match = in_use_q[idx_q] && (ram_rdata[DESC_W-1 -: KEY_W] == key_q);
		sts.scan_last = (idx_q == IW'(MAX_PROCS - 1));
		sts.found = found_q;
		sts.free_found = free_found_q;
		sts.head_is_p = (head_d_q == p_q);
		sts.tail_is_p = (tail_d_q == p_q);
		sts.prev_is_tail = (prev_q == tail_d_q);
		sts.next_is_p = (next_rd == p_q);
		sts.cnt_last = (cnt_q == PID_W'(NUM_PIDS - 1));
	end

	// Descriptor word is {key, head, tail}; every update rewrites the whole word.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = d_q;
		ram_wdata = {key_q, head_d_q, tail_d_q};
		if (cmd.ins_append) begin
			ram_we = 1'b1;
			ram_wdata = {key_q, head_d_q, p_q};
		end else if (cmd.ins_new) begin
			ram_we = 1'b1;
			ram_waddr = free_q;
			ram_wdata = {key_q, p_q, p_q};
		end else if (cmd.unlink_head && !sts.tail_is_p) begin
			ram_we = 1'b1;
			ram_wdata = {key_q, nextp_q, tail_d_q};
		end else if (cmd.unlink_mid && sts.tail_is_p) begin
			ram_we = 1'b1;
			ram_wdata = {key_q, head_d_q, prev_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			waiting_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.init) begin
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				idx_q <= '0;
			end
			if (cmd.hit) begin
				found_q <= 1'b1;
			end
			if (cmd.step) begin
				if (!in_use_q[idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.ins_append || cmd.ins_new) begin
				waiting_q[p_q] <= 1'b1;
			end
			if (cmd.ins_new) begin
				in_use_q[free_q] <= 1'b1;
			end
			if (cmd.unlink_head || cmd.unlink_mid) begin
				waiting_q[p_q] <= 1'b0;
			end
			if (cmd.unlink_head && sts.tail_is_p) begin
				in_use_q[d_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			key_q <= sem_addr;
			p_q <= proc_id;
		end
		if (cmd.init && op_q == OP_OUT) begin
			key_q <= wkey_q[p_q];
		end
		if (cmd.step && !in_use_q[idx_q] && !free_found_q) begin
			free_q <= idx_q;
		end
		if (cmd.hit) begin
			d_q <= idx_q;
			head_d_q <= ram_rdata[2*PID_W-1 -: PID_W];
			tail_d_q <= ram_rdata[PID_W-1:0];
		end
		if (cmd.from_head) begin
			p_q <= head_d_q;
		end
		if (cmd.rd_next) begin
			nextp_q <= next_rd;
			prev_q <= head_d_q;
			cnt_q <= '0;
		end
		if (cmd.walk_step) begin
			prev_q <= next_rd;
			cnt_q <= cnt_q + PID_W'(1);
		end
		if (cmd.ins_append) begin
			next_q[tail_d_q] <= p_q;
		end
		if (cmd.ins_append || cmd.ins_new) begin
			next_q[p_q] <= p_q;
			wkey_q[p_q] <= key_q;
		end
		if (cmd.unlink_mid) begin
			next_q[prev_q] <= nextp_q;
		end
		if (cmd.res_wr) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_sel)
				RES_PROC: res_proc_q <= p_q;
				RES_HEAD: res_proc_q <= head_d_q;
				default:  res_proc_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			result_proc_q <= res_proc_q;
		end
	end

	assign status = status_q;
	assign result_proc = result_proc_q;

endmodule

>>> rtl/semaphore_wait_queue_table_core.sv
`timescale 1ns / 1ps
// Flow: each request reads descriptors in turn, through states S_RD and S_CMP, until the key
// matches (all MAX_PROCS on a miss); remove and out then unlink a process, out walking the
// queue link by link from the head (up to 16). Rejected inserts and outs skip the scan.
// Throughput: one item at a time; the next transfer is taken only once the controller is
// back in idle.
// Reset: arst_n clears all descriptors and waiting flags at once; no clearing pass.
// ---------------------------------------------------------------------------
// Semaphore wait queue table core
// Active semaphore descriptors, each with a first-in first-out queue of
// blocked process ids, supporting insert, remove head, out and head peek.
// ---------------------------------------------------------------------------
module semaphore_wait_queue_table_core #(
	parameter int MAX_PROCS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [swqt_pkg::KEY_W-1:0]     sem_addr,
	input  logic [swqt_pkg::PID_W-1:0]     proc_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [swqt_pkg::PID_W-1:0]     result_proc
);
	import swqt_pkg::*;

	// The controller walks the states; the datapath holds all table storage.
	// They talk only through the command and status structs below.
	cmd_t cmd;
	sts_t sts;

	// The controller accepts a transfer only when idle. A finished result
	// sits in the output register until its transfer completes, while the
	// next item may already be accepted.
	swqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath scans descriptors through a RAM, keeps per-process links
	// and wait keys in registers, and walks a queue one link per cycle.
	swqt_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.sem_addr    (sem_addr),
		.proc_id     (proc_id),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.result_proc (result_proc)
	);

endmodule

>>> sim/semaphore_wait_queue_table_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Semaphore wait queue table core testbench
// Drives insert, remove, out and head requests through the valid/stall
// channels and compares every result transfer against a behavioral table.
// A directed table and a run that fills every descriptor come first, then
// random traffic over a small key pool in three idling phases.
// ---------------------------------------------------------------------------
module semaphore_wait_queue_table_core_tb;
	import swqt_pkg::*;

	localparam int NUM_DESC = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

	typedef struct packed {
		logic [1:0] status;
		logic [PID_W-1:0] proc;
	} reply_t;

	typedef struct {
		logic [1:0] op;
		logic [KEY_W-1:0] key;
		logic [PID_W-1:0] pid;
		bit fixed;
		logic [1:0] status;
		logic [PID_W-1:0] proc;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [KEY_W-1:0] sem_addr;
	logic [PID_W-1:0] proc_id;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [PID_W-1:0] result_proc;

	semaphore_wait_queue_table_core #(.MAX_PROCS(NUM_DESC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .sem_addr(sem_addr), .proc_id(proc_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_proc(result_proc)
	);

	// Behavioral copy of the table contents.
	bit desc_busy[NUM_DESC];
	logic [KEY_W-1:0] desc_addr[NUM_DESC];
	logic [PID_W-1:0] q_first[NUM_DESC];
	logic [PID_W-1:0] q_last[NUM_DESC];
	logic [PID_W-1:0] link[NUM_PIDS];
	logic [KEY_W-1:0] blocked_on[NUM_PIDS];
	bit blocked[NUM_PIDS];

	reply_t pending_replies[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_request = 0;
	int quiet_cycles = 0;

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int find_desc(logic [KEY_W-1:0] key);
		for (int i = 0; i < NUM_DESC; i++)
			if (desc_busy[i] && desc_addr[i] == key)
				return i;
		return -1;
	endfunction

	// Pull process p out of the queue of descriptor d; the walk follows the
	// links from the head and gives up at the tail.
	function automatic bit unlink(int d, logic [PID_W-1:0] p);
		logic [PID_W-1:0] prev;
		prev = q_first[d];
		if (prev == p) begin
			if (q_last[d] == p)
				desc_busy[d] = 1'b0;
			else
				q_first[d] = link[p];
			blocked[p] = 1'b0;
			return 1'b1;
		end
		for (int n = 0; n < NUM_PIDS; n++) begin
			if (prev == q_last[d])
				break;
			if (link[prev] == p) begin
				link[prev] = link[p];
				if (q_last[d] == p)
					q_last[d] = prev;
				blocked[p] = 1'b0;
				return 1'b1;
			end
			prev = link[prev];
		end
		return 1'b0;
	endfunction

	// Apply one request to the table and return the reply it must produce.
	function automatic reply_t table_update(logic [1:0] req, logic [KEY_W-1:0] key,
			logic [PID_W-1:0] p);
		reply_t r;
		int d;
		int f;
		r = '0;
		case (req)
			OP_INSERT: begin
				if (blocked[p]) begin
					r.status = ST_NOT_FOUND;
				end else begin
					d = find_desc(key);
					if (d >= 0) begin
						link[q_last[d]] = p;
						q_last[d] = p;
					end else begin
						f = -1;
						for (int i = NUM_DESC - 1; i >= 0; i--)
							if (!desc_busy[i])
								f = i;
						if (f >= 0) begin
							desc_busy[f] = 1'b1;
							desc_addr[f] = key;
							q_first[f] = p;
							q_last[f] = p;
						end else begin
							r.status = ST_FULL;
						end
					end
					if (r.status == ST_OK) begin
						link[p] = p;
						blocked_on[p] = key;
						blocked[p] = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				d = find_desc(key);
				if (d < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.proc = q_first[d];
					void'(unlink(d, r.proc));
				end
			end
			OP_OUT: begin
				if (!blocked[p]) begin
					r.status = ST_NOT_FOUND;
				end else begin
					d = find_desc(blocked_on[p]);
					if (d >= 0 && unlink(d, p))
						r.proc = p;
					else
						r.status = ST_NOT_FOUND;
				end
			end
			default: begin
				d = find_desc(key);
				if (d < 0)
					r.status = ST_NOT_FOUND;
				else
					r.proc = q_first[d];
			end
		endcase
		return r;
	endfunction

	// Offer one request and hold it until the block takes it. The reply is
	// predicted at the edge of the transfer; a typed value overrides it.
	task automatic offer(logic [1:0] req, logic [KEY_W-1:0] key, logic [PID_W-1:0] p,
			bit fixed = 1'b0, reply_t typed = '0);
		reply_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req;
		sem_addr <= key;
		proc_id <= p;
		do
			@(posedge clk);
		while (in_stall);
		r = table_update(req, key, p);
		pending_replies.push_back(fixed ? typed : r);
	endtask

	// Result side: random stall, a long hold-off on request, and the check.
	initial begin
		int hold;
		reply_t want;
		hold = 0;
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected result transfer status=%0d proc=%0d",
						$time, status, result_proc);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						errors++;
					end
					if (result_proc !== want.proc) begin
						$display("%0t: result_proc expected %0d actual %0d",
							$time, want.proc, result_proc);
						errors++;
					end
				end
			end
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("semaphore_wait_queue_table_core regression: fail");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		logic [KEY_W-1:0] pool[6];
		logic [KEY_W-1:0] key;
		int pick;
		int wait_cycles;

		in_valid = 1'b0;
		op = OP_INSERT;
		sem_addr = '0;
		proc_id = '0;
		arst_n = 1'b0;
		foreach (blocked[i])
			blocked[i] = 1'b0;
		foreach (desc_busy[i])
			desc_busy[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Rows marked fixed carry a reply readable at a glance.
		rows = '{
			'{OP_HEAD,   31'd5,    4'd0,  1'b1, ST_NOT_FOUND, 4'd0},
			'{OP_REMOVE, 31'd0,    4'd0,  1'b1, ST_NOT_FOUND, 4'd0},
			'{OP_OUT,    31'd0,    4'd3,  1'b1, ST_NOT_FOUND, 4'd0},
			'{OP_INSERT, 31'd0,    4'd0,  1'b1, ST_OK,        4'd0},
			'{OP_INSERT, KEY_ONES, 4'd15, 1'b1, ST_OK,        4'd0},
			'{OP_INSERT, KEY_ONES, 4'd15, 1'b1, ST_NOT_FOUND, 4'd0},
			'{OP_HEAD,   KEY_ONES, 4'd0,  1'b1, ST_OK,        4'd15},
			'{OP_INSERT, 31'd0,    4'd1,  1'b0, ST_OK,        4'd0},
			'{OP_INSERT, 31'd0,    4'd2,  1'b0, ST_OK,        4'd0},
			'{OP_INSERT, 31'd0,    4'd3,  1'b0, ST_OK,        4'd0},
			'{OP_OUT,    31'd0,    4'd2,  1'b0, ST_OK,        4'd0},
			'{OP_OUT,    31'd0,    4'd3,  1'b0, ST_OK,        4'd0},
			'{OP_HEAD,   31'd0,    4'd0,  1'b0, ST_OK,        4'd0},
			'{OP_REMOVE, 31'd0,    4'd0,  1'b0, ST_OK,        4'd0},
			'{OP_OUT,    31'd0,    4'd1,  1'b0, ST_OK,        4'd0},
			'{OP_REMOVE, 31'd0,    4'd0,  1'b1, ST_NOT_FOUND, 4'd0},
			'{OP_OUT,    31'd0,    4'd15, 1'b0, ST_OK,        4'd0},
			'{OP_HEAD,   KEY_ONES, 4'd0,  1'b1, ST_NOT_FOUND, 4'd0}
		};
		foreach (rows[i])
			offer(rows[i].op, rows[i].key, rows[i].pid, rows[i].fixed,
				{rows[i].status, rows[i].proc});

		// Every process blocked on its own address: all descriptors busy.
		for (int p = 0; p < NUM_PIDS; p++)
			offer(OP_INSERT, KEY_W'(32'h100 + p), PID_W'(p));
		offer(OP_INSERT, 31'h5555_5555, 4'd7);
		for (int p = 0; p < NUM_PIDS; p++)
			offer(OP_OUT, '0, PID_W'(p));

		// Random traffic over a small key pool so that queues grow and drain.
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 83 : 0;
			receiver_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 24 : 0;
			pool[0] = '0;
			pool[1] = KEY_ONES;
			for (int i = 2; i < 6; i++)
				pool[i] = KEY_W'($urandom());
			if (phase == 2)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < 410; n++) begin
				key = ($urandom_range(19) == 0) ? KEY_W'($urandom())
					: pool[$urandom_range(5)];
				pick = $urandom_range(99);
				if (pick < 40)
					offer(OP_INSERT, key, PID_W'($urandom_range(15)));
				else if (pick < 60)
					offer(OP_REMOVE, key, PID_W'($urandom_range(15)));
				else if (pick < 85)
					offer(OP_OUT, key, PID_W'($urandom_range(15)));
				else
					offer(OP_HEAD, key, PID_W'($urandom_range(15)));
			end
			// Pause the sender until the block has drained.
			in_valid <= 1'b0;
			while (pending_replies.size() != 0)
				@(posedge clk);
			@(posedge clk);
		end

		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_replies.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("semaphore_wait_queue_table_core regression: pass");
		else
			$display("semaphore_wait_queue_table_core regression: fail");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/swqt_pkg.sv
rtl/swqt_ram.sv
rtl/swqt_ctrl.sv
rtl/swqt_dpath.sv
rtl/semaphore_wait_queue_table_core.sv
sim/semaphore_wait_queue_table_core_tb.sv
